@@ hw/rtl/piea_pkg.sv @@
package piea_pkg;

	localparam int unsigned LEN_W = 7;
	localparam int unsigned WORD_W = 32;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_RESIZE = 3'd4
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RDWAIT,
		S_SHUP,
		S_INSFIN,
		S_SHDN,
		S_ZERO
	} state_t;

	typedef struct packed {
		logic [2:0]              operation;
		logic [LEN_W-1:0]        index;
		logic signed [WORD_W-1:0] value;
		logic [LEN_W-1:0]        new_length;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [LEN_W-1:0]        length;
		logic [1:0]              status;
	} result_t;

endpackage

@@ hw/rtl/piea_ram.sv @@
module piea_ram
	import piea_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/piea_seq.sv @@
module piea_seq
	import piea_pkg::*;
#(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned AW = 6,
	parameter int unsigned CW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output logic              done,
	output result_t           result,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [WORD_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [WORD_W-1:0] mem_rdata
);

	localparam int unsigned MW = (CW > LEN_W) ? CW : LEN_W;

	state_t          state_q, state_n;
	cmd_t            cmd_q;
	logic [CW-1:0]   count_q, count_n;
	logic [CW-1:0]   k_q, k_n;
	logic            done_q, done_n;
	result_t         res_q, res_n;
	logic [CW-1:0]   raddr_w;

	logic [MW-1:0]   idx_x, nlen_x, cnt_x, k_x, cap_x;

	assign idx_x  = MW'(cmd_q.index);
	assign nlen_x = MW'(cmd_q.new_length);
	assign cnt_x  = MW'(count_q);
	assign k_x    = MW'(k_q);
	assign cap_x  = MW'(CAPACITY);

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = res_q;
	assign mem_raddr = raddr_w[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			done_q  <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
		end
		k_q   <= k_n;
		res_q <= res_n;
	end

	always_comb begin
		state_n    = state_q;
		count_n    = count_q;
		k_n        = k_q;
		done_n     = 1'b0;
		res_n      = res_q;
		mem_we     = 1'b0;
		mem_waddr  = k_q[AW-1:0];
		mem_wdata  = mem_rdata;
		mem_re     = 1'b0;
		raddr_w    = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_n = S_EVAL;
				end
			end
			S_EVAL: begin
				state_n          = S_IDLE;
				done_n           = 1'b1;
				res_n.read_value = '0;
				res_n.status     = ST_OK;
				case (cmd_q.operation)
					OP_READ: begin
						if (idx_x < cnt_x) begin
							mem_re  = 1'b1;
							raddr_w = idx_x[CW-1:0];
							state_n = S_RDWAIT;
							done_n  = 1'b0;
						end else begin
							res_n.status = ST_RANGE;
						end
					end
					OP_WRITE: begin
						if (idx_x < cnt_x) begin
							mem_we    = 1'b1;
							mem_waddr = idx_x[AW-1:0];
							mem_wdata = cmd_q.value;
						end else begin
							res_n.status = ST_RANGE;
						end
					end
					OP_INSERT: begin
						if (cnt_x == cap_x) begin
							res_n.status = ST_FULL;
						end else if (idx_x > cnt_x) begin
							res_n.status = ST_RANGE;
						end else if (idx_x == cnt_x) begin
							mem_we    = 1'b1;
							mem_waddr = idx_x[AW-1:0];
							mem_wdata = cmd_q.value;
							count_n   = count_q + CW'(1);
						end else begin
							mem_re  = 1'b1;
							raddr_w = count_q - CW'(1);
							k_n     = count_q;
							state_n = S_SHUP;
							done_n  = 1'b0;
						end
					end
					OP_ERASE: begin
						if (count_q == '0) begin
							res_n.status = ST_EMPTY;
						end else if (idx_x >= cnt_x) begin
							res_n.status = ST_RANGE;
						end else if (idx_x + MW'(1) == cnt_x) begin
							count_n = count_q - CW'(1);
						end else begin
							mem_re  = 1'b1;
							raddr_w = idx_x[CW-1:0] + CW'(1);
							k_n     = idx_x[CW-1:0];
							state_n = S_SHDN;
							done_n  = 1'b0;
						end
					end
					OP_RESIZE: begin
						if (nlen_x > cap_x) begin
							res_n.status = ST_RANGE;
						end else if (nlen_x <= cnt_x) begin
							count_n = nlen_x[CW-1:0];
						end else begin
							k_n     = count_q;
							state_n = S_ZERO;
							done_n  = 1'b0;
						end
					end
					default: begin
					end
				endcase
				res_n.length = LEN_W'(count_n);
			end
			S_RDWAIT: begin
				state_n          = S_IDLE;
				done_n           = 1'b1;
				res_n.read_value = mem_rdata;
				res_n.status     = ST_OK;
				res_n.length     = LEN_W'(count_q);
			end
			S_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[AW-1:0];
				mem_wdata = mem_rdata;
				if (k_x - MW'(1) == idx_x) begin
					state_n = S_INSFIN;
				end else begin
					mem_re  = 1'b1;
					raddr_w = k_q - CW'(2);
					k_n     = k_q - CW'(1);
				end
			end
			S_INSFIN: begin
				mem_we           = 1'b1;
				mem_waddr        = idx_x[AW-1:0];
				mem_wdata        = cmd_q.value;
				count_n          = count_q + CW'(1);
				state_n          = S_IDLE;
				done_n           = 1'b1;
				res_n.read_value = '0;
				res_n.status     = ST_OK;
				res_n.length     = LEN_W'(count_n);
			end
			S_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[AW-1:0];
				mem_wdata = mem_rdata;
				if (k_x + MW'(2) == cnt_x) begin
					count_n          = count_q - CW'(1);
					state_n          = S_IDLE;
					done_n           = 1'b1;
					res_n.read_value = '0;
					res_n.status     = ST_OK;
					res_n.length     = LEN_W'(count_n);
				end else begin
					mem_re  = 1'b1;
					raddr_w = k_q + CW'(2);
					k_n     = k_q + CW'(1);
				end
			end
			S_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[AW-1:0];
				mem_wdata = '0;
				if (k_x + MW'(1) == nlen_x) begin
					count_n          = nlen_x[CW-1:0];
					state_n          = S_IDLE;
					done_n           = 1'b1;
					res_n.read_value = '0;
					res_n.status     = ST_OK;
					res_n.length     = LEN_W'(count_n);
				end else begin
					k_n = k_q + CW'(1);
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/positional_insert_erase_array_unit.sv @@
// Ordered list of up to CAPACITY signed 32-bit words with read, write, insert,
// erase and resize transactions. A transaction is taken when start is high and
// busy is low, and its single result appears on result for exactly one cycle
// with done high; the receiver cannot stall it, so it must take the result in
// that cycle. Moved or cleared entries pass one at a time through the word
// memory, which has one read and one write port. A read returns the
// registered memory output. An insert below the length moves each entry from
// the top down to the index up by one place and then writes the new value; an
// append writes it directly. An erase below the last entry moves each later
// entry down by one place. A growing resize writes zero to each new entry.
// The memory holds no reset value; entries at or beyond the length are never
// returned.
module positional_insert_erase_array_unit
	import piea_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	piea_seq #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	piea_ram #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
